/* design/dra_pkg.sv */
// Shared types, constants and helpers of the detection region activation block.
// Used by dra_ctrl, dra_datapath and detection_region_activation; no dependencies.
package dra_pkg;

   // tensor layout
   localparam int COORD_ENTRIES = 4;
   localparam int CLASS_BASE    = COORD_ENTRIES + 1;
   localparam int BOX_W         = 4;
   localparam int ENTRY_W       = 6;
   localparam int CLS_W         = 5;
   localparam int POS_W         = 9;

   // register map
   localparam logic [1:0] REG_BOX_COUNT   = 2'd0;
   localparam logic [1:0] REG_CLASS_COUNT = 2'd1;
   localparam logic [1:0] REG_PLANE_SIZE  = 2'd2;
   localparam logic [4:0] BOX_COUNT_RST   = 5'd5;
   localparam logic [4:0] CLASS_COUNT_RST = 5'd20;
   localparam logic [8:0] PLANE_SIZE_RST  = 9'd169;

   // arithmetic constants, Q30
   localparam logic [31:0] LOG2E_Q30    = 32'd1549082005;
   localparam logic [31:0] LN2_Q30      = 32'd744261118;
   localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
   localparam logic [2:0]  TAYLOR_ORDER = 3'd7;
   localparam int          DIV_STEPS    = 17;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_PASS,
      OP_T_ABS,
      OP_T_DIFF,
      OP_MUL_V,
      OP_MUL_G,
      OP_LATCH_G,
      OP_MUL_GR,
      OP_MUL_Q,
      OP_TAYLOR,
      OP_EXP_FIN,
      OP_DIV_LOGI,
      OP_DIV_SMAX,
      OP_DIV_STEP,
      OP_MEM_WR,
      OP_MEM_RD,
      OP_MAX,
      OP_ACC,
      OP_EX_RD,
      OP_EMIT
   } dra_op_type;

   typedef struct packed {
      dra_op_type         op;
      logic [CLS_W-1:0]   cls_idx;
      logic [POS_W-1:0]   pos;
      logic [2:0]         taylor_n;
      logic [BOX_W-1:0]   out_box;
      logic [4:0]         out_entry;
      logic [7:0]         out_pos;
      logic               out_last;
   } dra_cmd_type;

   typedef struct packed {
      logic out_free;
   } dra_status_type;

   // floor(2^32 / n) for the Taylor divisions; n = 1 bypasses the multiply
   function automatic logic [31:0] taylor_recip(input logic [2:0] n);
      logic [31:0] m;
      case (n)
         3'd2:    m = 32'd2147483648;
         3'd3:    m = 32'd1431655765;
         3'd4:    m = 32'd1073741824;
         3'd5:    m = 32'd858993459;
         3'd6:    m = 32'd715827882;
         3'd7:    m = 32'd613566756;
         default: m = 32'd0;
      endcase
      return m;
   endfunction

endpackage

/* design/dra_datapath.sv */
// Datapath of the region activation: class store, shared multiplier, exp
// series, serial divider and the result register. Depends on dra_pkg.
module dra_datapath #(
   parameter int MAX_CLASSES = 20,
   parameter int MAX_PLANE   = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dra_pkg::dra_cmd_type    cmd,
   output dra_pkg::dra_status_type status,
   input  logic signed [15:0]      req_sample,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [23:0]      rsp_result_value,
   output logic [3:0]              rsp_box_number,
   output logic [4:0]              rsp_entry_number,
   output logic [7:0]              rsp_position,
   output logic                    rsp_run_end
);
   import dra_pkg::*;

   localparam int DEPTH  = MAX_CLASSES * MAX_PLANE;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EXI_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int SUM_W  = 31 + $clog2(MAX_CLASSES);
   localparam int DIV_W  = (SUM_W > 32) ? SUM_W : 32;
   localparam int NUM_W  = DIV_W + DIV_STEPS;

   logic [15:0]       class_mem [DEPTH];
   logic [30:0]       exp_mem [MAX_CLASSES];
   logic [15:0]       rdata_ff;
   logic [30:0]       ex_rdata_ff;
   logic [ADDR_W-1:0] mem_addr;
   logic [EXI_W-1:0]  ex_idx;

   logic signed [15:0] x_ff, x_in;
   logic [15:0]        t_ff, t_in;
   logic [63:0]        prod_ff, prod_in;
   logic [8:0]         ip_ff, ip_in;
   logic [29:0]        g_ff, g_in;
   logic [30:0]        r_ff, r_in;
   logic [30:0]        q_ff, q_in;
   logic [30:0]        e_ff, e_in;
   logic signed [15:0] m_ff, m_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [DIV_W-1:0]   den_ff, den_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_STEPS-1:0] low_ff, low_in;
   logic [DIV_STEPS-1:0] quot_ff, quot_in;
   logic [23:0]        res_ff, res_in;
   logic               out_valid_ff, out_valid_in;
   logic signed [23:0] out_value_ff, out_value_in;
   logic [3:0]         out_box_ff, out_box_in;
   logic [4:0]         out_entry_ff, out_entry_in;
   logic [7:0]         out_pos_ff, out_pos_in;
   logic               out_last_ff, out_last_in;

   logic [31:0]       mul_a, mul_b;
   logic [31:0]       tay_est;
   logic [34:0]       tay_rem;
   logic [30:0]       tay_quot;
   logic [31:0]       logi_d;
   logic [NUM_W-1:0]  logi_num, sm_num, div_num;
   logic [DIV_W:0]    trial, trial_diff;
   logic              trial_ge;
   logic [16:0]       diff17;

   assign mem_addr = ADDR_W'(int'(cmd.cls_idx) * MAX_PLANE + int'(cmd.pos));
   assign ex_idx   = EXI_W'(cmd.cls_idx);

   always_ff @(posedge clock) begin
      if (cmd.op == OP_MEM_WR) class_mem[mem_addr] <= x_ff;
      if (cmd.op == OP_MEM_RD) rdata_ff <= class_mem[mem_addr];
      if (cmd.op == OP_ACC) exp_mem[ex_idx] <= e_ff;
      if (cmd.op == OP_EX_RD) ex_rdata_ff <= exp_mem[ex_idx];
   end

   always_comb begin
      case (cmd.op)
         OP_MUL_V: begin
            mul_a = 32'(t_ff);
            mul_b = LOG2E_Q30;
         end
         OP_MUL_G: begin
            mul_a = 32'(prod_ff[37:8]);
            mul_b = LN2_Q30;
         end
         OP_MUL_GR: begin
            mul_a = 32'(g_ff);
            mul_b = 32'(r_ff);
         end
         OP_MUL_Q: begin
            mul_a = 32'(prod_ff[60:30]);
            mul_b = taylor_recip(cmd.taylor_n);
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   // Taylor step: quotient by reciprocal, one correction
   assign tay_est  = prod_ff[63:32];
   assign tay_rem  = 35'(q_ff) - (35'(tay_est) * 35'(cmd.taylor_n));
   assign tay_quot = (cmd.taylor_n == 3'd1) ? q_ff :
                     (tay_est[30:0] + 31'(tay_rem >= 35'(cmd.taylor_n)));

   assign logi_d   = 32'(Q30_ONE) + 32'(e_ff);
   assign logi_num = x_ff[15] ? ((NUM_W'(e_ff) << 16) + NUM_W'(logi_d >> 1))
                              : ((NUM_W'(1) << 46) + NUM_W'(logi_d >> 1));
   assign sm_num   = (NUM_W'(ex_rdata_ff) << 16) + NUM_W'(sum_ff >> 1);
   assign div_num  = (cmd.op == OP_DIV_LOGI) ? logi_num : sm_num;

   assign trial      = {rem_ff, low_ff[DIV_STEPS-1]};
   assign trial_ge   = trial >= {1'b0, den_ff};
   assign trial_diff = trial - {1'b0, den_ff};

   assign diff17 = {m_ff[15], m_ff} - {rdata_ff[15], rdata_ff};

   always_comb begin
      x_in         = x_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      ip_in        = ip_ff;
      g_in         = g_ff;
      r_in         = r_ff;
      q_in         = q_ff;
      e_in         = e_ff;
      m_in         = m_ff;
      sum_in       = sum_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      low_in       = low_ff;
      quot_in      = quot_ff;
      res_in       = res_ff;
      out_value_in = out_value_ff;
      out_box_in   = out_box_ff;
      out_entry_in = out_entry_ff;
      out_pos_in   = out_pos_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      case (cmd.op)
         OP_CAPTURE: x_in = req_sample;
         OP_PASS:    res_in = {x_ff, 8'd0};
         OP_T_ABS:   t_in = x_ff[15] ? (16'd0 - 16'(x_ff)) : 16'(x_ff);
         OP_T_DIFF:  t_in = diff17[15:0];
         OP_MUL_V:   prod_in = {32'd0, mul_a} * {32'd0, mul_b};
         OP_MUL_G: begin
            ip_in   = prod_ff[46:38];
            prod_in = {32'd0, mul_a} * {32'd0, mul_b};
         end
         OP_LATCH_G: begin
            g_in = prod_ff[59:30];
            r_in = Q30_ONE;
         end
         OP_MUL_GR:  prod_in = {32'd0, mul_a} * {32'd0, mul_b};
         OP_MUL_Q: begin
            q_in    = prod_ff[60:30];
            prod_in = {32'd0, mul_a} * {32'd0, mul_b};
         end
         OP_TAYLOR:  r_in = Q30_ONE - tay_quot;
         OP_EXP_FIN: e_in = (ip_ff >= 9'd31) ? 31'd0 : (r_ff >> ip_ff[4:0]);
         OP_DIV_LOGI, OP_DIV_SMAX: begin
            den_in  = (cmd.op == OP_DIV_LOGI) ? DIV_W'(logi_d) : DIV_W'(sum_ff);
            rem_in  = div_num[NUM_W-1:DIV_STEPS];
            low_in  = div_num[DIV_STEPS-1:0];
            quot_in = '0;
         end
         OP_DIV_STEP: begin
            rem_in  = trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
            low_in  = low_ff << 1;
            quot_in = {quot_ff[DIV_STEPS-2:0], trial_ge};
            res_in  = 24'({quot_ff[DIV_STEPS-2:0], trial_ge});
         end
         OP_MAX: begin
            if (cmd.cls_idx == '0 || $signed(rdata_ff) > m_ff) m_in = rdata_ff;
         end
         OP_ACC: sum_in = ((cmd.cls_idx == '0) ? '0 : sum_ff) + SUM_W'(e_ff);
         OP_EMIT: begin
            out_valid_in = 1'b1;
            out_value_in = res_ff;
            out_box_in   = cmd.out_box;
            out_entry_in = cmd.out_entry;
            out_pos_in   = cmd.out_pos;
            out_last_in  = cmd.out_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      x_ff         <= x_in;
      t_ff         <= t_in;
      prod_ff      <= prod_in;
      ip_ff        <= ip_in;
      g_ff         <= g_in;
      r_ff         <= r_in;
      q_ff         <= q_in;
      e_ff         <= e_in;
      m_ff         <= m_in;
      sum_ff       <= sum_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      low_ff       <= low_in;
      quot_ff      <= quot_in;
      res_ff       <= res_in;
      out_value_ff <= out_value_in;
      out_box_ff   <= out_box_in;
      out_entry_ff <= out_entry_in;
      out_pos_ff   <= out_pos_in;
      out_last_ff  <= out_last_in;
   end

   assign status.out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid        = out_valid_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_box_number   = out_box_ff;
   assign rsp_entry_number = out_entry_ff;
   assign rsp_position     = out_pos_ff;
   assign rsp_run_end      = out_last_ff;

endmodule

/* design/dra_ctrl.sv */
// Controller of the region activation: configuration registers, tensor
// counters and the sequencing state machine. Depends on dra_pkg.
module dra_ctrl #(
   parameter int MAX_CLASSES = 20,
   parameter int MAX_PLANE   = 256,
   parameter int MAX_BOXES   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [8:0]              csr_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  dra_pkg::dra_status_type status,
   output dra_pkg::dra_cmd_type    cmd
);
   import dra_pkg::*;

   typedef enum logic [21:0] {
      S_IDLE     = 22'h000001,
      S_PASS     = 22'h000002,
      S_LOGI_T   = 22'h000004,
      S_EXP_V    = 22'h000008,
      S_EXP_G    = 22'h000010,
      S_EXP_GL   = 22'h000020,
      S_TAY_GR   = 22'h000040,
      S_TAY_Q    = 22'h000080,
      S_TAY_UPD  = 22'h000100,
      S_EXP_FIN  = 22'h000200,
      S_LOGI_DIV = 22'h000400,
      S_DIV_STEP = 22'h000800,
      S_EMIT     = 22'h001000,
      S_CLS_WR   = 22'h002000,
      S_MAX_RD   = 22'h004000,
      S_MAX_UPD  = 22'h008000,
      S_SUM_RD   = 22'h010000,
      S_SUM_T    = 22'h020000,
      S_SUM_ACC  = 22'h040000,
      S_OUT_RD   = 22'h080000,
      S_OUT_DIV  = 22'h100000,
      S_SPARE    = 22'h200000
   } state_type;

   state_type          state_ff, state_in;
   logic [4:0]         box_cnt_ff, box_cnt_in;
   logic [4:0]         class_cnt_ff, class_cnt_in;
   logic [8:0]         plane_ff, plane_in;
   logic [BOX_W-1:0]   box_ff, box_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [BOX_W-1:0]   cur_box_ff, cur_box_in;
   logic [ENTRY_W-1:0] cur_entry_ff, cur_entry_in;
   logic [POS_W-1:0]   cur_pos_ff, cur_pos_in;
   logic               smax_ff, smax_in;
   logic [CLS_W-1:0]   k_ff, k_in;
   logic [2:0]         n_ff, n_in;
   logic [4:0]         div_cnt_ff, div_cnt_in;

   logic [4:0]         nb;
   logic [4:0]         nc;
   logic [8:0]         np;
   logic [ENTRY_W-1:0] entries;
   logic [CLS_W-1:0]   cur_cls;
   logic               k_last;

   assign nb = (box_cnt_ff == 5'd0) ? 5'd1 :
               ((int'(box_cnt_ff) > MAX_BOXES) ? 5'(MAX_BOXES) : box_cnt_ff);
   assign nc = (class_cnt_ff == 5'd0) ? 5'd1 :
               ((int'(class_cnt_ff) > MAX_CLASSES) ? 5'(MAX_CLASSES) : class_cnt_ff);
   assign np = (plane_ff == 9'd0) ? 9'd1 :
               ((int'(plane_ff) > MAX_PLANE) ? 9'(MAX_PLANE) : plane_ff);
   assign entries = ENTRY_W'(CLASS_BASE) + ENTRY_W'(nc);
   assign cur_cls = CLS_W'(cur_entry_ff - ENTRY_W'(CLASS_BASE));
   assign k_last  = (k_ff == nc - 5'd1);

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      box_cnt_in   = box_cnt_ff;
      class_cnt_in = class_cnt_ff;
      plane_in     = plane_ff;
      box_in       = box_ff;
      entry_in     = entry_ff;
      pos_in       = pos_ff;
      cur_box_in   = cur_box_ff;
      cur_entry_in = cur_entry_ff;
      cur_pos_in   = cur_pos_ff;
      smax_in      = smax_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      div_cnt_in   = div_cnt_ff;
      cmd.op       = OP_NONE;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op       = OP_CAPTURE;
               cur_box_in   = box_ff;
               cur_entry_in = entry_ff;
               cur_pos_in   = pos_ff;
               smax_in      = 1'b0;
               if ({1'b0, pos_ff} + 10'd1 >= {1'b0, np}) begin
                  pos_in = '0;
                  if ({1'b0, entry_ff} + 7'd1 >= {1'b0, entries}) begin
                     entry_in = '0;
                     box_in   = ({1'b0, box_ff} + 5'd1 >= nb) ? '0 : box_ff + 4'd1;
                  end else begin
                     entry_in = entry_ff + 6'd1;
                  end
               end else begin
                  pos_in = pos_ff + 9'd1;
               end
               if (entry_ff >= ENTRY_W'(CLASS_BASE)) begin
                  state_in = S_CLS_WR;
               end else if (entry_ff inside {6'd2, 6'd3}) begin
                  state_in = S_PASS;
               end else begin
                  state_in = S_LOGI_T;
               end
            end
         end
         S_PASS: begin
            cmd.op   = OP_PASS;
            state_in = S_EMIT;
         end
         S_LOGI_T: begin
            cmd.op   = OP_T_ABS;
            state_in = S_EXP_V;
         end
         S_EXP_V: begin
            cmd.op   = OP_MUL_V;
            state_in = S_EXP_G;
         end
         S_EXP_G: begin
            cmd.op   = OP_MUL_G;
            state_in = S_EXP_GL;
         end
         S_EXP_GL: begin
            cmd.op   = OP_LATCH_G;
            n_in     = TAYLOR_ORDER;
            state_in = S_TAY_GR;
         end
         S_TAY_GR: begin
            cmd.op   = OP_MUL_GR;
            state_in = S_TAY_Q;
         end
         S_TAY_Q: begin
            cmd.op   = OP_MUL_Q;
            state_in = S_TAY_UPD;
         end
         S_TAY_UPD: begin
            cmd.op = OP_TAYLOR;
            if (n_ff == 3'd1) begin
               state_in = S_EXP_FIN;
            end else begin
               n_in     = n_ff - 3'd1;
               state_in = S_TAY_GR;
            end
         end
         S_EXP_FIN: begin
            cmd.op   = OP_EXP_FIN;
            state_in = smax_ff ? S_SUM_ACC : S_LOGI_DIV;
         end
         S_LOGI_DIV: begin
            cmd.op     = OP_DIV_LOGI;
            div_cnt_in = '0;
            state_in   = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            cmd.op = OP_DIV_STEP;
            if (div_cnt_ff == 5'(DIV_STEPS - 1)) begin
               state_in = S_EMIT;
            end else begin
               div_cnt_in = div_cnt_ff + 5'd1;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.op = OP_EMIT;
               if (smax_ff && !k_last) begin
                  k_in     = k_ff + 5'd1;
                  state_in = S_OUT_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CLS_WR: begin
            cmd.op = OP_MEM_WR;
            if (cur_cls == nc - 5'd1) begin
               smax_in  = 1'b1;
               k_in     = '0;
               state_in = S_MAX_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MAX_RD: begin
            cmd.op   = OP_MEM_RD;
            state_in = S_MAX_UPD;
         end
         S_MAX_UPD: begin
            cmd.op = OP_MAX;
            if (k_last) begin
               k_in     = '0;
               state_in = S_SUM_RD;
            end else begin
               k_in     = k_ff + 5'd1;
               state_in = S_MAX_RD;
            end
         end
         S_SUM_RD: begin
            cmd.op   = OP_MEM_RD;
            state_in = S_SUM_T;
         end
         S_SUM_T: begin
            cmd.op   = OP_T_DIFF;
            state_in = S_EXP_V;
         end
         S_SUM_ACC: begin
            cmd.op = OP_ACC;
            if (k_last) begin
               k_in     = '0;
               state_in = S_OUT_RD;
            end else begin
               k_in     = k_ff + 5'd1;
               state_in = S_SUM_RD;
            end
         end
         S_OUT_RD: begin
            cmd.op   = OP_EX_RD;
            state_in = S_OUT_DIV;
         end
         S_OUT_DIV: begin
            cmd.op     = OP_DIV_SMAX;
            div_cnt_in = '0;
            state_in   = S_DIV_STEP;
         end
         default: state_in = S_IDLE;
      endcase

      // register writes restart the stream at box 0, entry 0, position 0
      if (csr_valid) begin
         if (csr_index inside {REG_BOX_COUNT, REG_CLASS_COUNT, REG_PLANE_SIZE}) begin
            box_in   = '0;
            entry_in = '0;
            pos_in   = '0;
         end
         case (csr_index)
            REG_BOX_COUNT:   box_cnt_in   = csr_data[4:0];
            REG_CLASS_COUNT: class_cnt_in = csr_data[4:0];
            REG_PLANE_SIZE:  plane_in     = csr_data;
            default: ;
         endcase
      end

      cmd.cls_idx   = (state_ff == S_CLS_WR) ? cur_cls : k_ff;
      cmd.pos       = cur_pos_ff;
      cmd.taylor_n  = n_ff;
      cmd.out_box   = cur_box_ff;
      cmd.out_entry = smax_ff ? (5'(CLASS_BASE) + k_ff) : cur_entry_ff[4:0];
      cmd.out_pos   = cur_pos_ff[7:0];
      cmd.out_last  = !smax_ff || k_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         box_cnt_ff   <= BOX_COUNT_RST;
         class_cnt_ff <= CLASS_COUNT_RST;
         plane_ff     <= PLANE_SIZE_RST;
         box_ff       <= '0;
         entry_ff     <= '0;
         pos_ff       <= '0;
         smax_ff      <= 1'b0;
         k_ff         <= '0;
         n_ff         <= '0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         box_cnt_ff   <= box_cnt_in;
         class_cnt_ff <= class_cnt_in;
         plane_ff     <= plane_in;
         box_ff       <= box_in;
         entry_ff     <= entry_in;
         pos_ff       <= pos_in;
         smax_ff      <= smax_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
         div_cnt_ff   <= div_cnt_in;
      end
      cur_box_ff   <= cur_box_in;
      cur_entry_ff <= cur_entry_in;
      cur_pos_ff   <= cur_pos_in;
   end

endmodule

/* design/detection_region_activation.sv */
// Top level of the detection region activation block.
// Joins dra_ctrl and dra_datapath; depends on dra_pkg.
//
// Usage:
//  - req_ channel: one Q7.8 tensor element per transfer, channel-major per
//    anchor box (4 coordinate planes, objectness, then the class planes).
//  - rsp_ channel: Q7.16 results tagged with box, entry and position;
//    rsp_run_end marks the last result caused by one input transfer.
//  - csr_ channel: box_count, class_count, plane_size at index 0, 1, 2.
//    Any write to a known index restarts the stream at box 0.
// Processing, one item at a time through the shared multiplier and
// the bit-serial divider:
//  - width/height: passed through; x, y, objectness: |x| and exp
//    sequence, divider load plus 17 steps, emit.
//  - class element: stored; the last class of a position also
//    runs the softmax over all classes of that position.
// Reset: counters clear, registers take 5 / 20 / 169; the class store is
// not cleared. A stalled rsp_ transfer holds the result register and the
// sequencer waits; req_stall is high whenever an item is in work.
module detection_region_activation #(
   parameter int MAX_CLASSES = 20,
   parameter int MAX_PLANE   = 256,
   parameter int MAX_BOXES   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [8:0]         csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_result_value,
   output logic [3:0]         rsp_box_number,
   output logic [4:0]         rsp_entry_number,
   output logic [7:0]         rsp_position,
   output logic               rsp_run_end
);
   import dra_pkg::*;

   dra_cmd_type    cmd;
   dra_status_type status;

   // sequencer: config, counters, softmax walk
   dra_ctrl #(
      .MAX_CLASSES(MAX_CLASSES),
      .MAX_PLANE  (MAX_PLANE),
      .MAX_BOXES  (MAX_BOXES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   // arithmetic, class store, result register
   dra_datapath #(
      .MAX_CLASSES(MAX_CLASSES),
      .MAX_PLANE  (MAX_PLANE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_value(rsp_result_value),
      .rsp_box_number  (rsp_box_number),
      .rsp_entry_number(rsp_entry_number),
      .rsp_position    (rsp_position),
      .rsp_run_end     (rsp_run_end)
   );

`ifndef NO_ASSERTIONS
   // an accepted item always keeps the block busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not blocked after transfer");

   // coordinate and objectness results are single-result runs
   a_coord_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_entry_number < 5'(CLASS_BASE)) |-> rsp_run_end)
      else $error("coordinate result without run end");

   // activated values never exceed 1.0 in Q7.16
   a_prob_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_entry_number == 5'd0 || rsp_entry_number == 5'd1 ||
                     rsp_entry_number >= 5'(CLASS_BASE - 1)))
      |-> (rsp_result_value >= 24'sd0 && rsp_result_value <= 24'sd65536))
      else $error("activated value out of range");
`endif

endmodule

/* test/tb_top.sv */
// Self-checking testbench of detection_region_activation: streams Q7.8 tensor
// elements through phases of register settings and checks every result.
// Depends on dra_pkg and the detection_region_activation RTL.
`timescale 1ns / 1ps

module tb_top;
   import dra_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;  // no register at this index
   localparam int SETTLE_CYCLES = 1200;       // worst softmax run, 20 classes

   typedef struct {
      logic [23:0] value;
      logic [3:0]  box;
      logic [4:0]  entry;
      logic [7:0]  pos;
      logic        last;
   } region_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [8:0]         csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_sample = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [23:0] rsp_result_value;
   logic [3:0]         rsp_box_number;
   logic [4:0]         rsp_entry_number;
   logic [7:0]         rsp_position;
   logic               rsp_run_end;

   detection_region_activation dut (.*);

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor: a private copy of the registers, the stream counters and
   // the class buffer, advanced once per accepted req_ transfer.
   // ---------------------------------------------------------------------
   int unsigned       boxes_reg, classes_reg, plane_reg;
   int unsigned       box_ptr, entry_ptr, pos_ptr;
   logic [15:0]       class_buf [20][256];
   region_result_type results_due[$];
   int                errors = 0;

   function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   // exp(-t/256) in Q30: 2^-(t*log2 e), fractional part by Taylor series
   function automatic longint unsigned exp_neg_q30(int unsigned t);
      longint unsigned one, v, ip, f, g, r;
      one = 64'd1 << 30;
      v  = 64'(t) * 64'(LOG2E_Q30);
      ip = v >> 38;
      f  = (v >> 8) & (one - 1);
      g  = (f * 64'(LN2_Q30)) >> 30;
      r  = one;
      for (int n = 7; n >= 1; n--)
         r = one - ((g * r) >> 30) / 64'(n);
      if (ip >= 31)
         return 0;
      return r >> ip;
   endfunction

   function automatic longint unsigned logistic_q16(int x);
      longint unsigned e, d;
      e = exp_neg_q30((x < 0) ? -x : x);
      d = (64'd1 << 30) + e;
      if (x >= 0)
         return ((64'd1 << 46) + d / 2) / d;
      return ((e << 16) + d / 2) / d;
   endfunction

   task automatic push_result(longint unsigned v, int unsigned e, bit last);
      region_result_type r;
      r.value = v[23:0];
      r.box   = box_ptr[3:0];
      r.entry = e[4:0];
      r.pos   = pos_ptr[7:0];
      r.last  = last;
      results_due.push_back(r);
   endtask

   task automatic region_predict(logic [15:0] raw);
      int unsigned     nb, nc, np, cls;
      int              x, peak, v;
      longint unsigned ex [20];
      longint unsigned sum;
      nb = clamp(boxes_reg, 1, 16);
      nc = clamp(classes_reg, 1, 20);
      np = clamp(plane_reg, 1, 256);
      x  = $signed(raw);
      if (entry_ptr < CLASS_BASE) begin
         if (entry_ptr == 2 || entry_ptr == 3)
            push_result(longint'(x * 256), entry_ptr, 1'b1);
         else
            push_result(logistic_q16(x), entry_ptr, 1'b1);
      end else begin
         cls = entry_ptr - CLASS_BASE;
         class_buf[cls][pos_ptr] = raw;
         // last class plane of this position: softmax over all classes
         if (cls + 1 >= nc) begin
            peak = $signed(class_buf[0][pos_ptr]);
            for (int k = 1; k < nc; k++) begin
               v = $signed(class_buf[k][pos_ptr]);
               if (v > peak) peak = v;
            end
            sum = 0;
            for (int k = 0; k < nc; k++) begin
               ex[k] = exp_neg_q30(peak - $signed(class_buf[k][pos_ptr]));
               sum += ex[k];
            end
            for (int k = 0; k < nc; k++)
               push_result(((ex[k] << 16) + sum / 2) / sum, CLASS_BASE + k, k + 1 == nc);
         end
      end
      // counters: position, then entry, then box, wrapping at batch end
      if (pos_ptr + 1 >= np) begin
         pos_ptr = 0;
         if (entry_ptr + 1 >= CLASS_BASE + nc) begin
            entry_ptr = 0;
            box_ptr = (box_ptr + 1 >= nb) ? 0 : box_ptr + 1;
         end else begin
            entry_ptr++;
         end
      end else begin
         pos_ptr++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Request driver: feeds samples from the pending queue, with random gaps
   // between transfers. Acceptance is seen at the rising edge.
   // ---------------------------------------------------------------------
   logic [15:0] samples_pending[$];
   bit          req_busy = 0;
   bit          calm = 0;        // no idling on either side while set
   int          req_gap = 0;

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         region_predict(req_sample);
         req_busy = 0;
      end
   end

   always @(negedge clock) begin
      int r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_busy) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (samples_pending.size() > 0) begin
            req_sample <= samples_pending.pop_front();
            req_valid  <= 1'b1;
            req_busy = 1;
            r = $urandom_range(0, 99);
            if (calm || r < 55)
               req_gap = 0;
            else if (r < 92)
               req_gap = $urandom_range(1, 3);
            else
               req_gap = $urandom_range(8, 40);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result side: random stall, plus a long hold-off on request so the
   // block backs up and holds req_stall while the sender keeps offering.
   // ---------------------------------------------------------------------
   int stall_left = 0;
   int long_hold = 0;            // set by the sequence, consumed here

   always @(negedge clock) begin
      int r;
      if (long_hold > 0) begin
         stall_left = long_hold;
         long_hold = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (!calm && r < 25)
            stall_left = (r < 3) ? $urandom_range(10, 60) : $urandom_range(0, 2);
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      region_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            $display("%0t: unexpected result value=%h box=%0d entry=%0d pos=%0d end=%b",
                     $time, rsp_result_value, rsp_box_number, rsp_entry_number,
                     rsp_position, rsp_run_end);
            errors++;
         end else begin
            want = results_due.pop_front();
            if (rsp_result_value !== want.value) begin
               $display("%0t: result_value expected %h actual %h (box %0d entry %0d pos %0d)",
                        $time, want.value, rsp_result_value, want.box, want.entry, want.pos);
               errors++;
            end
            if (rsp_box_number !== want.box) begin
               $display("%0t: box_number expected %0d actual %0d",
                        $time, want.box, rsp_box_number);
               errors++;
            end
            if (rsp_entry_number !== want.entry) begin
               $display("%0t: entry_number expected %0d actual %0d",
                        $time, want.entry, rsp_entry_number);
               errors++;
            end
            if (rsp_position !== want.pos) begin
               $display("%0t: position expected %0d actual %0d",
                        $time, want.pos, rsp_position);
               errors++;
            end
            if (rsp_run_end !== want.last) begin
               $display("%0t: run_end expected %b actual %b",
                        $time, want.last, rsp_run_end);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   task automatic csr_write(logic [1:0] idx, logic [8:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_BOX_COUNT:   boxes_reg   = data & 9'h1F;
         REG_CLASS_COUNT: classes_reg = data & 9'h1F;
         REG_PLANE_SIZE:  plane_reg   = data;
         default: ;
      endcase
      // a known register restarts the stream
      if (idx != REG_UNUSED) begin
         box_ptr = 0;
         entry_ptr = 0;
         pos_ptr = 0;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_shape(logic [8:0] nb, logic [8:0] nc, logic [8:0] np);
      csr_write(REG_BOX_COUNT, nb);
      csr_write(REG_CLASS_COUNT, nc);
      csr_write(REG_PLANE_SIZE, np);
   endtask

   // sender pause: everything sent, every result back, block settled
   task automatic drain();
      while (samples_pending.size() > 0 || req_busy || results_due.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30)
         return 16'($urandom);
      if (r < 80)
         return 16'($urandom_range(0, 2047) - 1024);
      case ($urandom_range(0, 3))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   task automatic fill(int n);
      repeat (n) samples_pending.push_back(rand_sample());
   endtask

   initial begin
      int fed;
      boxes_reg   = BOX_COUNT_RST;
      classes_reg = CLASS_COUNT_RST;
      plane_reg   = PLANE_SIZE_RST;
      box_ptr = 0;
      entry_ptr = 0;
      pos_ptr = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset shape: first plane is x, all logistic
      fill(8);
      drain();

      // directed: one box, two classes, one position; coordinate and
      // class extremes, then a batch wrap back to box 0
      set_shape(9'd1, 9'd2, 9'd1);
      samples_pending = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000,
                          16'h7FFF, 16'h8000,
                          16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'h0100,
                          16'h0000, 16'h0000};
      drain();
      // one class, two positions: coordinate and objectness values of both signs
      set_shape(9'd2, 9'd1, 9'd2);
      samples_pending = '{16'h0180, 16'hFE80, 16'h0001, 16'hFFFF, 16'h0200,
                          16'hFE00, 16'h0000, 16'h7FFF, 16'h5555, 16'hAAAA};
      drain();

      // values below range clamp up to one
      set_shape(9'h000, 9'h000, 9'h000);
      fill(14);
      drain();
      // unknown index: no effect, stream carries on where it was
      csr_write(REG_UNUSED, 9'h1FF);
      fill(6);
      drain();
      // values above range clamp to 16 boxes, 20 classes, 256 positions
      set_shape(9'h1FF, 9'h1FF, 9'h1FF);
      fill(24);
      drain();
      // widest softmax: 20 classes at a single position, two boxes
      set_shape(9'd2, 9'd20, 9'd1);
      fill(50);
      drain();

      // long receiver hold while the sender keeps offering
      set_shape(9'd2, 9'd3, 9'd2);
      fill(30);
      long_hold = 400;
      drain();

      // random shapes, mostly small; some phases run with no idling
      fed = 0;
      while (fed < 140) begin
         int n;
         n = $urandom_range(15, 35);
         calm = ($urandom_range(0, 5) == 0);
         set_shape(9'($urandom_range(1, 3)), 9'($urandom_range(1, 5)),
                   9'($urandom_range(1, 4)));
         fill(n);
         drain();
         fed += n;
      end
      calm = 0;

      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
